// File: rtl/core/gf256_polynomial_sector_mac_macros.svh
// Assertion macros used by the checker file of the sector MAC.
`ifndef GF256_POLYNOMIAL_SECTOR_MAC_MACROS_SVH
`define GF256_POLYNOMIAL_SECTOR_MAC_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GPSM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gpsm check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GPSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gpsm check failed");

`endif

// File: rtl/core/gpsm_pkg.sv
// Types, register codes and GF(2^8) arithmetic for the sector MAC.
`timescale 1ns / 1ps

package gpsm_pkg;

	localparam int CFG_DATA_W  = 13;
	localparam int CFG_INDEX_W = 3;
	localparam int KEY_REGS    = 4;

	localparam logic [CFG_INDEX_W-1:0] REG_SECTOR_SIZE = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_COUNT   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_A       = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_B       = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_C       = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_D       = 3'd5;

	localparam logic [CFG_DATA_W-1:0] SECTOR_SIZE_RESET = 13'd512;
	localparam logic [2:0]            KEY_COUNT_RESET   = 3'd3;
	localparam logic [7:0]            KEY_RESET [KEY_REGS] = '{8'd123, 8'd200, 8'd15, 8'd0};

	// Low byte of the reduction polynomial x^8 + x^4 + x^3 + x + 1.
	localparam logic [7:0] REDUCE_LOW = 8'h1B;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_data;
	} byte_req_t;

	typedef struct packed {
		logic [7:0] tag;
		logic [1:0] key_index;
		logic       last_tag;
	} tag_rsp_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// Shift-and-add multiply in GF(2^8), reduced by 0x11B.
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] x;
		logic [7:0] acc;
		x = a;
		acc = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				acc = acc ^ x;
			end
			x = x[7] ? ((x << 1) ^ REDUCE_LOW) : (x << 1);
		end
		return acc;
	endfunction

endpackage

// File: rtl/core/gpsm_front.sv
// Front end: takes bytes, tracks sector position, updates tags and key powers.
`timescale 1ns / 1ps

module gpsm_front #(
	parameter int SLOTS      = 4,
	parameter int MAX_SECTOR = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                byte_valid,
	output logic                                byte_ready,
	input  gpsm_pkg::byte_req_t                 byte_req,
	input  logic [SLOTS-1:0][7:0]               keys,
	input  logic [gpsm_pkg::CFG_DATA_W-1:0]     sector_size,
	input  logic [2:0]                          key_count,
	input  gpsm_pkg::fifo_stat_t                fifo_stat,
	output logic                                push,
	output logic [SLOTS-1:0][7:0]               push_tags,
	output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] push_last
);

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int POS_W  = (MAX_SECTOR > 1) ? $clog2(MAX_SECTOR) : 1;
	localparam int SIZE_W = POS_W + 1;
	localparam int CMP_W  = (SIZE_W > gpsm_pkg::CFG_DATA_W) ? SIZE_W : gpsm_pkg::CFG_DATA_W;

	logic [POS_W-1:0]  pos_q;
	logic [CMP_W-1:0]  size_ext;
	logic [SIZE_W-1:0] size_lim;
	logic [SIZE_W-1:0] count_nxt;
	logic              accept;
	logic              closing;
	logic              first;

	assign byte_ready = !fifo_stat.full;
	assign accept     = byte_valid && byte_ready;

	// Clamp the sector size into 1..MAX_SECTOR.
	always_comb begin
		size_ext = CMP_W'(sector_size);
		if (size_ext == '0) begin
			size_lim = SIZE_W'(1);
		end else if (size_ext > CMP_W'(MAX_SECTOR)) begin
			size_lim = SIZE_W'(MAX_SECTOR);
		end else begin
			size_lim = SIZE_W'(size_ext);
		end
	end

	assign count_nxt = {1'b0, pos_q} + SIZE_W'(1);
	assign closing   = byte_req.end_of_data || (count_nxt >= size_lim);
	assign first     = (pos_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= closing ? '0 : count_nxt[POS_W-1:0];
		end
	end

	for (genvar k = 0; k < SLOTS; k++) begin : g_slot
		logic [7:0] acc_q;
		logic [7:0] pow_q;
		logic [7:0] pw;
		logic [7:0] base;
		logic [7:0] acc_nxt;

		// A new sector starts from the key itself and an empty tag.
		assign pw      = first ? keys[k] : pow_q;
		assign base    = first ? 8'd0 : acc_q;
		assign acc_nxt = base ^ gpsm_pkg::gf_mul(byte_req.data_byte, pw);

		always_ff @(posedge clk) begin
			if (accept) begin
				acc_q <= acc_nxt;
				pow_q <= gpsm_pkg::gf_mul(pw, keys[k]);
			end
		end

		assign push_tags[k] = acc_nxt;
	end

	// Index of the final tag: key count clamped into 1..SLOTS, minus one.
	always_comb begin
		if (key_count == '0) begin
			push_last = '0;
		end else if (key_count > 3'(SLOTS)) begin
			push_last = SLOT_W'(SLOTS - 1);
		end else begin
			push_last = SLOT_W'(key_count - 3'd1);
		end
	end

	assign push = accept && closing;

endmodule

// File: rtl/core/gpsm_fifo.sv
// Two-entry queue of finished tag sets between front and back.
`timescale 1ns / 1ps

module gpsm_fifo #(
	parameter int WIDTH = 34
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 pop,
	output logic [WIDTH-1:0]     head,
	output gpsm_pkg::fifo_stat_t stat
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

// File: rtl/core/gpsm_emit.sv
// Back end: walks a tag set and sends one tag per cycle, while tag_ready is high, through an output register.
`timescale 1ns / 1ps

module gpsm_emit #(
	parameter int SLOTS = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gpsm_pkg::fifo_stat_t  fifo_stat,
	input  logic [SLOTS-1:0][7:0] head_tags,
	input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] head_last,
	output logic                  pop,
	output logic                  tag_valid,
	input  logic                  tag_ready,
	output gpsm_pkg::tag_rsp_t    tag_rsp
);

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [SLOT_W-1:0]  k_q;
	logic               valid_q;
	gpsm_pkg::tag_rsp_t rsp_q;
	logic               load;
	logic               is_last;

	assign load    = !fifo_stat.empty && (!valid_q || tag_ready);
	assign is_last = (k_q == head_last);
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			k_q     <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				k_q     <= is_last ? '0 : k_q + SLOT_W'(1);
			end else if (tag_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q.tag       <= head_tags[k_q];
			rsp_q.key_index <= 2'(k_q);
			rsp_q.last_tag  <= is_last;
		end
	end

	assign tag_valid = valid_q;
	assign tag_rsp   = rsp_q;

endmodule

// File: rtl/core/gf256_polynomial_sector_mac.sv
// Top level of the GF(2^8) polynomial sector MAC.
`timescale 1ns / 1ps
//
// Usage:
//   Byte channel (byte_valid/byte_ready/byte_req): one request per byte of the
//   stream; end_of_data on a byte closes a short final sector.
//   Tag channel (tag_valid/tag_ready/tag_rsp): when a sector closes, one tag per
//   key in use goes out in key order, last_tag set on the final one.
//   Config port (cfg_wen/cfg_index/cfg_wdata): write-only registers, sector
//   size, key count and the four keys; write them only while the block is idle.
// Timing:
//   One byte per cycle while the queue is not full. The closing byte's tags are
//   captured into a two-entry queue at acceptance; with the output idle the first
//   tag then moves from the queue into the output register, and further tags follow
//   one per cycle while tag_ready is high. Sustained rate is bound by the single
//   output register, and byte_ready drops only while the queue holds two unsent tag sets.
// Reset: arst_n clears position, queue and output; registers take their default
//   values (512 bytes, 3 keys, keys 123, 200, 15, 0). No clearing pass is needed.
// Stall: a low tag_ready holds the current tag in place; the front keeps taking
//   bytes until the queue fills.

module gf256_polynomial_sector_mac #(
	parameter int MAX_KEYS   = 4,
	parameter int MAX_SECTOR = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            byte_valid,
	output logic                            byte_ready,
	input  gpsm_pkg::byte_req_t             byte_req,
	output logic                            tag_valid,
	input  logic                            tag_ready,
	output gpsm_pkg::tag_rsp_t              tag_rsp,
	input  logic                            cfg_wen,
	input  logic [gpsm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [gpsm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	// Slots beyond the fourth key register never produce a tag.
	localparam int SLOTS   = (MAX_KEYS < gpsm_pkg::KEY_REGS) ? MAX_KEYS : gpsm_pkg::KEY_REGS;
	localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ENTRY_W = SLOTS * 8 + SLOT_W;

	logic [gpsm_pkg::CFG_DATA_W-1:0] sector_size_q;
	logic [2:0]                      key_count_q;
	logic [SLOTS-1:0][7:0]           keys_q;

	gpsm_pkg::fifo_stat_t  fifo_stat;
	logic                  push;
	logic                  pop;
	logic [SLOTS-1:0][7:0] push_tags;
	logic [SLOT_W-1:0]     push_last;
	logic [ENTRY_W-1:0]    head;
	logic [SLOTS-1:0][7:0] head_tags;
	logic [SLOT_W-1:0]     head_last;

	// Register file: unknown indexes drop the write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sector_size_q <= gpsm_pkg::SECTOR_SIZE_RESET;
			key_count_q   <= gpsm_pkg::KEY_COUNT_RESET;
		end else if (cfg_wen) begin
			if (cfg_index == gpsm_pkg::REG_SECTOR_SIZE) begin
				sector_size_q <= cfg_wdata;
			end
			if (cfg_index == gpsm_pkg::REG_KEY_COUNT) begin
				key_count_q <= cfg_wdata[2:0];
			end
		end
	end

	// Key slot k sits at REG_KEY_A + k (A, B, C, D in order).
	for (genvar k = 0; k < SLOTS; k++) begin : g_key
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				keys_q[k] <= gpsm_pkg::KEY_RESET[k];
			end else if (cfg_wen &&
					cfg_index == gpsm_pkg::REG_KEY_A + gpsm_pkg::CFG_INDEX_W'(k)) begin
				keys_q[k] <= cfg_wdata[7:0];
			end
		end
	end

	gpsm_front #(
		.SLOTS      (SLOTS),
		.MAX_SECTOR (MAX_SECTOR)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_ready  (byte_ready),
		.byte_req    (byte_req),
		.keys        (keys_q),
		.sector_size (sector_size_q),
		.key_count   (key_count_q),
		.fifo_stat   (fifo_stat),
		.push        (push),
		.push_tags   (push_tags),
		.push_last   (push_last)
	);

	gpsm_fifo #(
		.WIDTH (ENTRY_W)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({push_tags, push_last}),
		.pop    (pop),
		.head   (head),
		.stat   (fifo_stat)
	);

	assign head_tags = head[ENTRY_W-1:SLOT_W];
	assign head_last = head[SLOT_W-1:0];

	gpsm_emit #(
		.SLOTS (SLOTS)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.fifo_stat (fifo_stat),
		.head_tags (head_tags),
		.head_last (head_last),
		.pop       (pop),
		.tag_valid (tag_valid),
		.tag_ready (tag_ready),
		.tag_rsp   (tag_rsp)
	);

endmodule

// File: rtl/core/gpsm_checker.sv
// Port-level checks for the sector MAC, bound to the top level.
`timescale 1ns / 1ps
`include "gf256_polynomial_sector_mac_macros.svh"

module gpsm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               byte_ready,
	input logic               tag_valid,
	input logic               tag_ready,
	input gpsm_pkg::tag_rsp_t tag_rsp
);

	logic [1:0] exp_idx_q;

	// Track the key index the next tag must carry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
		end else if (tag_valid && tag_ready) begin
			exp_idx_q <= tag_rsp.last_tag ? '0 : exp_idx_q + 2'd1;
		end
	end

	`GPSM_ASSERT_IMPL(a_idx_order, clk, arst_n, tag_valid, tag_rsp.key_index == exp_idx_q)
	`GPSM_ASSERT_IMPL(a_slot3_last, clk, arst_n, tag_valid && tag_rsp.key_index == 2'd3, tag_rsp.last_tag)
	`GPSM_ASSERT_IMPL(a_stall_has_tags, clk, arst_n, !byte_ready, tag_valid)
	`GPSM_ASSERT_NEXT(a_tag_hold, clk, arst_n, tag_valid && !tag_ready, tag_valid && $stable(tag_rsp))

endmodule

bind gf256_polynomial_sector_mac gpsm_checker u_checker (.*);

// File: tb/sv/gf256_polynomial_sector_mac_tb.sv
// Self-checking bench for the GF(2^8) sector MAC: byte streams in, every tag checked against a predictor.
`timescale 1ns / 1ps

module gf256_polynomial_sector_mac_tb;
	import gpsm_pkg::*;

	localparam int MAX_KEYS     = 4;
	localparam int MAX_SECTOR   = 4096;
	localparam int TAG_SLOTS    = (MAX_KEYS < KEY_REGS) ? MAX_KEYS : KEY_REGS;
	localparam int RANDOM_BYTES = 230;
	// Margin left after the last owed tag has been taken.
	localparam int DRAIN_SLACK  = 6;
	localparam logic [8:0] GF_POLY = 9'h11B;

	// Register indexes the block does not decode; writes to them must be ignored.
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;
	localparam logic [CFG_INDEX_W-1:0] KEY_REG_IDX [KEY_REGS] =
		'{REG_KEY_A, REG_KEY_B, REG_KEY_C, REG_KEY_D};

	// Tag predictor: own copy of the registers and of the per-key accumulators,
	// plus the queue of tags still owed by the block.
	class sector_tag_board;
		logic [CFG_DATA_W-1:0] size_reg;
		logic [2:0]            count_reg;
		logic [7:0]            key_reg [KEY_REGS];
		logic [7:0]            tag_acc [KEY_REGS];
		logic [7:0]            key_pow [KEY_REGS];
		int unsigned           fill;
		tag_rsp_t              tags_due [$];
		int                    errors;

		function new();
			size_reg  = SECTOR_SIZE_RESET;
			count_reg = KEY_COUNT_RESET;
			foreach (key_reg[k]) key_reg[k] = KEY_RESET[k];
			errors = 0;
			restart();
		endfunction

		function void restart();
			foreach (tag_acc[k]) begin
				tag_acc[k] = 8'h00;
				key_pow[k] = key_reg[k];
			end
			fill = 0;
		endfunction

		// Carry-less product, then fold the high bits back with the field polynomial.
		function logic [7:0] gf_times(logic [7:0] a, logic [7:0] b);
			logic [14:0] wide;
			wide = '0;
			for (int i = 0; i < 8; i++) begin
				if (b[i]) wide ^= 15'(a) << i;
			end
			for (int i = 14; i >= 8; i--) begin
				if (wide[i]) wide ^= 15'(GF_POLY) << (i - 8);
			end
			return wide[7:0];
		endfunction

		function int unsigned sector_len();
			if (size_reg == 0) return 1;
			if (size_reg > MAX_SECTOR) return MAX_SECTOR;
			return size_reg;
		endfunction

		function int tag_count();
			if (count_reg == 0) return 1;
			if (count_reg > TAG_SLOTS) return TAG_SLOTS;
			return count_reg;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_SECTOR_SIZE: size_reg = val;
				REG_KEY_COUNT:   count_reg = val[2:0];
				REG_KEY_A:       key_reg[0] = val[7:0];
				REG_KEY_B:       key_reg[1] = val[7:0];
				REG_KEY_C:       key_reg[2] = val[7:0];
				REG_KEY_D:       key_reg[3] = val[7:0];
				default: ;
			endcase
		endfunction

		// Fold one accepted byte into every slot; on a closing byte queue the tags.
		function void take_byte(byte_req_t req);
			logic [7:0] pw;
			tag_rsp_t   t;
			int         n;
			n = tag_count();
			for (int k = 0; k < KEY_REGS; k++) begin
				pw = (fill == 0) ? key_reg[k] : key_pow[k];
				tag_acc[k] = ((fill == 0) ? 8'h00 : tag_acc[k]) ^ gf_times(req.data_byte, pw);
				key_pow[k] = gf_times(pw, key_reg[k]);
			end
			if (fill + 1 >= sector_len() || req.end_of_data) begin
				for (int k = 0; k < n; k++) begin
					t.tag       = tag_acc[k];
					t.key_index = 2'(k);
					t.last_tag  = (k == n - 1);
					tags_due.push_back(t);
				end
				restart();
			end else begin
				fill++;
			end
		endfunction

		function void check_tag(tag_rsp_t got);
			tag_rsp_t want;
			if (tags_due.size() == 0) begin
				$display("%0t: unexpected tag, expected none, actual tag=%02h key=%0d last=%0b",
					$time, got.tag, got.key_index, got.last_tag);
				errors++;
				return;
			end
			want = tags_due.pop_front();
			if (got.tag !== want.tag) begin
				$display("%0t: tag mismatch, expected %02h actual %02h", $time, want.tag, got.tag);
				errors++;
			end
			if (got.key_index !== want.key_index) begin
				$display("%0t: key_index mismatch, expected %0d actual %0d",
					$time, want.key_index, got.key_index);
				errors++;
			end
			if (got.last_tag !== want.last_tag) begin
				$display("%0t: last_tag mismatch, expected %0b actual %0b",
					$time, want.last_tag, got.last_tag);
				errors++;
			end
		endfunction

		function int pending();
			return tags_due.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   byte_valid;
	logic                   byte_ready;
	byte_req_t              byte_req;
	logic                   tag_valid;
	logic                   tag_ready;
	tag_rsp_t               tag_rsp;
	logic                   cfg_wen;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	// Upper bound of the idle draw on both sides; zero gives back-to-back stretches.
	int                     max_gap = 5;
	int                     bytes_sent = 0;
	sector_tag_board        mac_board = new();

	gf256_polynomial_sector_mac #(
		.MAX_KEYS  (MAX_KEYS),
		.MAX_SECTOR(MAX_SECTOR)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_req  (byte_req),
		.tag_valid (tag_valid),
		.tag_ready (tag_ready),
		.tag_rsp   (tag_rsp),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Hard stop well past the slowest legal run.
	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Offer one byte request. Valid is only dropped when an idle gap is drawn,
	// so a back-to-back request keeps valid high with a single assignment.
	task automatic push_byte(input logic [7:0] data, input logic eod);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_req   <= '{data_byte: data, end_of_data: eod};
		// Hold the request until the edge that takes it.
		do @(posedge clk); while (!byte_ready);
		mac_board.take_byte(byte_req);
		bytes_sent++;
	endtask

	// Drop valid, wait for every owed tag, then let the pipeline go quiet.
	task automatic drain_tags();
		byte_valid <= 1'b0;
		while (mac_board.pending() != 0) @(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	// One-cycle register write; only called with the block drained.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		mac_board.write_reg(idx, val);
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	// Bias toward the field extremes; zero and one are the interesting keys too.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return 8'h01;
			default: return 8'($urandom);
		endcase
	endfunction

	// Redraw part of the configuration; junk in the unused upper bits must be masked.
	task automatic shuffle_config();
		logic [CFG_DATA_W-1:0] sz;
		if ($urandom_range(0, 2) != 0) begin
			case ($urandom_range(0, 9))
				0:       sz = '0;
				1:       sz = CFG_DATA_W'($urandom_range(MAX_SECTOR + 1, 8191));
				2:       sz = CFG_DATA_W'($urandom_range(9, 40));
				default: sz = CFG_DATA_W'($urandom_range(1, 8));
			endcase
			write_reg(REG_SECTOR_SIZE, sz);
		end
		if ($urandom_range(0, 1) != 0) write_reg(REG_KEY_COUNT, CFG_DATA_W'($urandom));
		for (int k = 0; k < KEY_REGS; k++) begin
			if ($urandom_range(0, 1) != 0)
				write_reg(KEY_REG_IDX[k], {5'($urandom), pick_byte()});
		end
		if ($urandom_range(0, 7) == 0)
			write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_6 : REG_SPARE_7,
				CFG_DATA_W'($urandom));
	endtask

	// Tag side: draw a stall per tag, then take whatever the block presents.
	initial begin : tag_sink
		int stall;
		tag_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, max_gap);
			if (stall > 0) begin
				tag_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			tag_ready <= 1'b1;
			do @(posedge clk); while (!tag_valid);
			mac_board.check_tag(tag_rsp);
		end
	end

	initial begin : byte_source
		int unsigned span;
		int          len;
		logic        eod;

		arst_n     <= 1'b0;
		byte_valid <= 1'b0;
		byte_req   <= '0;
		cfg_wen    <= 1'b0;
		cfg_index  <= REG_SECTOR_SIZE;
		cfg_wdata  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: short final sector closed by end of data, three tags.
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h01, 1'b1);
		drain_tags();

		// Size zero acts as one byte per sector, key count zero as one key.
		write_reg(REG_SECTOR_SIZE, '0);
		write_reg(REG_KEY_COUNT, '0);
		write_reg(REG_KEY_A, 13'h0FF);
		write_reg(REG_KEY_B, 13'h001);
		write_reg(REG_KEY_C, 13'h080);
		write_reg(REG_KEY_D, 13'h002);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h5A, 1'b1);
		drain_tags();

		// Key count above the slots saturates; end of data on a full sector closes once.
		write_reg(REG_KEY_COUNT, CFG_DATA_W'(7));
		write_reg(REG_SECTOR_SIZE, CFG_DATA_W'(3));
		push_byte(8'h12, 1'b0);
		push_byte(8'h34, 1'b0);
		push_byte(8'h56, 1'b1);
		// Swap a key in the middle of a sector: only later powers see it.
		push_byte(8'hAA, 1'b0);
		drain_tags();
		write_reg(REG_KEY_A, 13'h053);
		push_byte(8'hC3, 1'b0);
		push_byte(8'h3C, 1'b0);
		drain_tags();

		// Shrink the sector and the key count mid-sector; spare indexes do nothing.
		write_reg(REG_SECTOR_SIZE, CFG_DATA_W'(6));
		write_reg(REG_KEY_COUNT, CFG_DATA_W'(4));
		push_byte(8'h01, 1'b0);
		push_byte(8'h02, 1'b0);
		push_byte(8'h04, 1'b0);
		push_byte(8'h08, 1'b0);
		drain_tags();
		write_reg(REG_SECTOR_SIZE, CFG_DATA_W'(2));
		write_reg(REG_KEY_COUNT, CFG_DATA_W'(2));
		write_reg(REG_SPARE_6, '1);
		write_reg(REG_SPARE_7, '1);
		push_byte(8'h10, 1'b0);
		drain_tags();

		write_reg(REG_KEY_COUNT, CFG_DATA_W'(1));
		write_reg(REG_KEY_B, '0);
		write_reg(REG_SECTOR_SIZE, CFG_DATA_W'(1));
		push_byte(8'hFF, 1'b1);
		drain_tags();

		// Oversized sector saturates: a short run must stay open until end of data.
		write_reg(REG_SECTOR_SIZE, '1);
		write_reg(REG_KEY_COUNT, CFG_DATA_W'(4));
		for (int k = 0; k < KEY_REGS; k++) write_reg(KEY_REG_IDX[k], {5'h1F, pick_byte()});
		for (int i = 0; i < 19; i++) push_byte(pick_byte(), 1'b0);
		push_byte(pick_byte(), 1'b1);
		drain_tags();

		// Random phases: mostly sectors that fill or end cleanly, with stray end
		// markers and unfinished sectors mixed in.
		bytes_sent = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			shuffle_config();
			max_gap = ($urandom_range(0, 3) == 0) ? 0 : 5;
			repeat ($urandom_range(2, 6)) begin
				span = mac_board.sector_len();
				if (span > 24) span = 24;
				len = $urandom_range(1, span);
				for (int j = 0; j < len; j++) begin
					if (j == len - 1) begin
						if (len < mac_board.sector_len())
							eod = ($urandom_range(0, 4) != 0);
						else
							eod = ($urandom_range(0, 3) == 0);
					end else begin
						eod = ($urandom_range(0, 63) == 0);
					end
					push_byte(pick_byte(), eod);
				end
			end
			// Now and then retune a key while a sector may still be open.
			if ($urandom_range(0, 3) == 0) begin
				drain_tags();
				write_reg(KEY_REG_IDX[$urandom_range(0, KEY_REGS - 1)], {5'($urandom), pick_byte()});
				repeat ($urandom_range(1, 4)) push_byte(pick_byte(), 1'b0);
			end
			drain_tags();
		end

		drain_tags();
		if (mac_board.errors == 0 && mac_board.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
